[sv/mtnc_pkg.sv]
// shared types, sizes and character codes for the markup tag nesting checker
`default_nettype none

package mtnc_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int NAME_BYTES  = 32;

	localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
	localparam int PTR_W   = $clog2(STACK_DEPTH);
	localparam int LEN_W   = $clog2(NAME_BYTES + 1);
	localparam int ADDR_W  = $clog2(STACK_DEPTH * NAME_BYTES);
	localparam int DEPTH_W = 6;
	localparam int LIMIT_W = 6;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(20);

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;

	typedef enum logic [2:0] {
		MODE_TEXT       = 3'd0,
		MODE_AFTER_LT   = 3'd1,
		MODE_SKIP       = 3'd2,
		MODE_NAME       = 3'd3,
		MODE_CLOSE_REST = 3'd4,
		MODE_OPEN_REST  = 3'd5
	} parse_mode_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_CLOSE_EMPTY = 3'd1,
		ST_MISMATCH    = 3'd2,
		ST_STACK_FULL  = 3'd3,
		ST_ENDED_IN_TAG = 3'd4,
		ST_NAME_LONG   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_PUSH    = 3'd1,
		EV_POP     = 3'd2,
		EV_SELF    = 3'd3,
		EV_IGNORED = 3'd4
	} tag_event_t;

	typedef struct packed {
		logic [7:0] byte_req;
		logic       last;
	} item_t;

	typedef struct packed {
		status_t              status;
		logic [DEPTH_W-1:0]   depth;
		tag_event_t           tag_event;
	} result_t;

endpackage

`default_nettype wire

[sv/mtnc_ram.sv]
// generic simple dual-port ram with registered read
`default_nettype none

module mtnc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[sv/markup_tag_nesting_checker.sv]
// top level: byte-serial markup tag nesting checker with name stack
// pipeline: an accepted byte is held in the input register, its result in the result register
// throughput: one byte per cycle unless stalled; the whole parse step (name compare against the
//   prefetched stack byte, push or pop) fits between the input and result registers
// reset: parser to text mode, depth 0, no error, depth_limit to 20
// reset: the name stack memory is not cleared; entries are only read after a push
`default_nettype none

module markup_tag_nesting_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                item_valid,
	output logic                                     item_ready,
	input  wire mtnc_pkg::item_t                     item,
	output logic                                     result_valid,
	input  wire logic                                result_ready,
	output mtnc_pkg::result_t                        result,
	input  wire logic                                cfg_we,
	input  wire logic [mtnc_pkg::LIMIT_W-1:0]        cfg_wdata
);

	localparam int CW = mtnc_pkg::CNT_W;
	localparam int PW = mtnc_pkg::PTR_W;
	localparam int LW = mtnc_pkg::LEN_W;
	localparam int AW = mtnc_pkg::ADDR_W;
	localparam int DW = mtnc_pkg::DEPTH_W;

	// input stage and result stage
	logic              valid_s1;
	mtnc_pkg::item_t   item_s1;
	logic              valid_s2;
	mtnc_pkg::result_t result_s2;
	logic              advance;

	// parser state
	mtnc_pkg::parse_mode_t mode_q, mode_n;
	logic                  closing_q, closing_n;
	logic                  saw_q, saw_n;
	logic [LW-1:0]         len_q, len_n;
	logic                  slash_q, slash_n;
	logic                  match_q, match_n;
	logic [CW-1:0]         cnt_q, cnt_n;
	mtnc_pkg::status_t     err_q, err_n;
	mtnc_pkg::tag_event_t  ev_n;
	logic [mtnc_pkg::LIMIT_W-1:0] limit_q;

	// name length stack, one entry per open tag
	logic [LW-1:0] len_stack [mtnc_pkg::STACK_DEPTH];
	logic [LW-1:0] top_len;
	logic          len_we;

	// name byte stack memory
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;

	// working values of the step
	logic [7:0]    c;
	logic          c_space;
	logic          name_path;
	logic          nm_closing;
	logic [LW-1:0] nm_len;
	logic          nm_slash;
	logic          nm_match;
	logic          do_finish;
	logic          fin_self;
	logic [CW-1:0] lim_eff;
	logic [CW-1:0] rd_cnt;
	logic [LW-1:0] rd_len;

	// handshake: a byte moves into the parse step whenever the result slot frees up
	assign advance      = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready   = !valid_s1 || advance;
	assign result_valid = valid_s2;
	assign result       = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
		if (advance) begin
			result_s2.status    <= err_n;
			result_s2.depth     <= DW'(cnt_n);
			result_s2.tag_event <= ev_n;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= mtnc_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// zero acts as one, anything past the stack size acts as the stack size
	always_comb begin
		if (limit_q == '0) begin
			lim_eff = CW'(1);
		end else if (int'(limit_q) > mtnc_pkg::STACK_DEPTH) begin
			lim_eff = CW'(mtnc_pkg::STACK_DEPTH);
		end else begin
			lim_eff = CW'(limit_q);
		end
	end

	// parser state registers, frozen between transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= mtnc_pkg::MODE_TEXT;
			closing_q <= 1'b0;
			saw_q     <= 1'b0;
			len_q     <= '0;
			slash_q   <= 1'b0;
			match_q   <= 1'b1;
			cnt_q     <= '0;
			err_q     <= mtnc_pkg::ST_OK;
		end else if (advance) begin
			mode_q    <= mode_n;
			closing_q <= closing_n;
			saw_q     <= saw_n;
			len_q     <= len_n;
			slash_q   <= slash_n;
			match_q   <= match_n;
			cnt_q     <= cnt_n;
			err_q     <= err_n;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && len_we) begin
			len_stack[PW'(cnt_q)] <= nm_len;
		end
	end

	assign top_len = len_stack[PW'(cnt_q - CW'(1))];

	assign c       = item_s1.byte_req;
	assign c_space = (c == mtnc_pkg::CH_SPACE) || (c == mtnc_pkg::CH_TAB) ||
		(c == mtnc_pkg::CH_NL);

	// a byte right after '<' that is not '?', '!' or '/' opens a name and is its first byte
	assign name_path = (mode_q == mtnc_pkg::MODE_NAME) ||
		((mode_q == mtnc_pkg::MODE_AFTER_LT) && (c != mtnc_pkg::CH_QUEST) &&
		(c != mtnc_pkg::CH_BANG) && (c != mtnc_pkg::CH_SLASH));

	// name state as seen by this byte: fresh when the name starts here
	always_comb begin
		if (mode_q == mtnc_pkg::MODE_AFTER_LT) begin
			nm_closing = 1'b0;
			nm_len     = '0;
			nm_slash   = 1'b0;
			nm_match   = 1'b1;
		end else begin
			nm_closing = closing_q;
			nm_len     = len_q;
			nm_slash   = slash_q;
			nm_match   = match_q;
		end
	end

	// one parse step
	always_comb begin
		mode_n    = mode_q;
		closing_n = closing_q;
		saw_n     = saw_q;
		len_n     = len_q;
		slash_n   = slash_q;
		match_n   = match_q;
		cnt_n     = cnt_q;
		err_n     = err_q;
		ev_n      = mtnc_pkg::EV_NONE;
		mem_we    = 1'b0;
		len_we    = 1'b0;
		do_finish = 1'b0;
		fin_self  = 1'b0;

		if (err_q == mtnc_pkg::ST_OK) begin
			unique case (mode_q)
				mtnc_pkg::MODE_TEXT: begin
					if (c == mtnc_pkg::CH_LT) begin
						mode_n = mtnc_pkg::MODE_AFTER_LT;
					end
				end
				mtnc_pkg::MODE_AFTER_LT: begin
					if ((c == mtnc_pkg::CH_QUEST) || (c == mtnc_pkg::CH_BANG)) begin
						mode_n = mtnc_pkg::MODE_SKIP;
					end else if (c == mtnc_pkg::CH_SLASH) begin
						mode_n    = mtnc_pkg::MODE_NAME;
						closing_n = 1'b1;
						len_n     = '0;
						slash_n   = 1'b0;
						match_n   = 1'b1;
					end else begin
						mode_n    = mtnc_pkg::MODE_NAME;
						closing_n = 1'b0;
						len_n     = '0;
						slash_n   = 1'b0;
						match_n   = 1'b1;
					end
				end
				mtnc_pkg::MODE_NAME: ;
				mtnc_pkg::MODE_OPEN_REST: begin
					if (c == mtnc_pkg::CH_GT) begin
						do_finish = 1'b1;
						fin_self  = slash_q || saw_q;
					end else begin
						saw_n = (c == mtnc_pkg::CH_SLASH);
					end
				end
				mtnc_pkg::MODE_SKIP, mtnc_pkg::MODE_CLOSE_REST: begin
					if (c == mtnc_pkg::CH_GT) begin
						mode_n = mtnc_pkg::MODE_TEXT;
					end
				end
				default: ;
			endcase

			if (name_path) begin
				if ((c == mtnc_pkg::CH_GT) || c_space) begin
					// end of the name
					if (nm_closing) begin
						if (cnt_q == '0) begin
							err_n = mtnc_pkg::ST_CLOSE_EMPTY;
						end else if (nm_slash) begin
							ev_n   = mtnc_pkg::EV_IGNORED;
							mode_n = (c == mtnc_pkg::CH_GT) ? mtnc_pkg::MODE_TEXT :
								mtnc_pkg::MODE_CLOSE_REST;
						end else if (nm_match && (nm_len == top_len)) begin
							cnt_n  = cnt_q - CW'(1);
							ev_n   = mtnc_pkg::EV_POP;
							mode_n = (c == mtnc_pkg::CH_GT) ? mtnc_pkg::MODE_TEXT :
								mtnc_pkg::MODE_CLOSE_REST;
						end else begin
							err_n = mtnc_pkg::ST_MISMATCH;
						end
					end else begin
						saw_n = 1'b0;
						if (c == mtnc_pkg::CH_GT) begin
							do_finish = 1'b1;
							fin_self  = nm_slash;
						end else begin
							mode_n = mtnc_pkg::MODE_OPEN_REST;
						end
					end
				end else if (nm_len >= LW'(mtnc_pkg::NAME_BYTES)) begin
					err_n = mtnc_pkg::ST_NAME_LONG;
				end else begin
					// closing names compare against the top entry, opening names are stored
					if (nm_closing) begin
						if ((cnt_q != '0) && ((nm_len >= top_len) || (mem_rdata != c))) begin
							match_n = 1'b0;
						end
					end else if (cnt_q < CW'(mtnc_pkg::STACK_DEPTH)) begin
						mem_we = 1'b1;
					end
					slash_n = (c == mtnc_pkg::CH_SLASH);
					len_n   = nm_len + LW'(1);
				end
			end

			if (do_finish) begin
				mode_n = mtnc_pkg::MODE_TEXT;
				if (fin_self) begin
					ev_n = mtnc_pkg::EV_SELF;
				end else if (cnt_q >= lim_eff) begin
					err_n = mtnc_pkg::ST_STACK_FULL;
				end else begin
					len_we = 1'b1;
					cnt_n  = cnt_q + CW'(1);
					ev_n   = mtnc_pkg::EV_PUSH;
				end
			end

			if ((err_n == mtnc_pkg::ST_OK) && item_s1.last &&
				(mode_n != mtnc_pkg::MODE_TEXT)) begin
				err_n = mtnc_pkg::ST_ENDED_IN_TAG;
			end
			if (err_n != mtnc_pkg::ST_OK) begin
				ev_n = mtnc_pkg::EV_NONE;
			end
		end
	end

	// stack byte write goes to the open slot at the current name position
	assign mem_waddr = AW'(cnt_q) * AW'(mtnc_pkg::NAME_BYTES) + AW'(nm_len);

	// prefetch: read the top entry byte the next name byte will be checked against
	assign rd_cnt    = advance ? cnt_n : cnt_q;
	assign rd_len    = advance ? len_n : len_q;
	assign mem_raddr = AW'(PW'(rd_cnt - CW'(1))) * AW'(mtnc_pkg::NAME_BYTES) +
		AW'(rd_len);

	mtnc_ram #(
		.WIDTH(8),
		.DEPTH(mtnc_pkg::STACK_DEPTH * mtnc_pkg::NAME_BYTES)
	) u_name_ram (
		.clk   (clk),
		.we    (advance && mem_we),
		.waddr (mem_waddr),
		.wdata (c),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

`ifndef SYNTHESIS
	// first error stays until reset
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != mtnc_pkg::ST_OK) |=> (err_q == $past(err_q)))
		else $error("error code changed after being set");

	// open tag count stays within the stack
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= mtnc_pkg::STACK_DEPTH)
		else $error("open tag count beyond stack depth");

	// the count moves only on a processed transaction
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(cnt_q))
		else $error("open tag count changed without a transaction");

	// a push raises the count by exactly one
	a_push_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (ev_n == mtnc_pkg::EV_PUSH)) |=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("push did not raise the count by one");

	// tag events only come with an ok status
	a_event_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (result_s2.tag_event != mtnc_pkg::EV_NONE)) |->
		(result_s2.status == mtnc_pkg::ST_OK))
		else $error("tag event reported alongside an error");
`endif

endmodule

`default_nettype wire

[bench/tb.sv]
// self-checking bench for the markup tag nesting checker: directed document, then random markup
`timescale 1ns / 1ps

module tb;
	import mtnc_pkg::*;

	// one byte of the directed document, with a hand-written result where it is obvious
	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} doc_row_t;

	// clock, reset and block ports; the inputs driven here are known from time zero
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_ready;
	item_t               item = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	result_t             result;
	logic                cfg_we = 1'b0;
	logic [LIMIT_W-1:0]  cfg_wdata = '0;

	// results still owed by the block, oldest first
	result_t awaited_results[$];
	result_t head;
	int      fails = 0;
	int      bytes_sent = 0;

	// idling knobs, changed per phase
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int rx_hold_req = 0;

	// parser mirror: mode, current name, open tag stack and sticky error
	logic [LIMIT_W-1:0] p_limit = LIMIT_RESET;
	parse_mode_t        p_mode = MODE_TEXT;
	bit                 p_closing = 1'b0;
	bit                 p_saw_slash = 1'b0;
	bit                 p_ends_slash = 1'b0;
	bit                 p_match = 1'b1;
	int                 p_len = 0;
	int                 p_count = 0;
	logic [7:0]         p_names [STACK_DEPTH][NAME_BYTES];
	int                 p_lens [STACK_DEPTH];
	status_t            p_err = ST_OK;
	tag_event_t         p_event = EV_NONE;

	// stack of names the stimulus has opened, so that closes can match them
	logic [7:0] gen_names [STACK_DEPTH][NAME_BYTES];
	int         gen_lens [STACK_DEPTH];
	int         gen_depth = 0;
	int         gen_cap = 20;

	// per-phase depth limits: top of range, zero, above range, one, then random
	logic [LIMIT_W-1:0] phase_limit [5] = '{6'd32, 6'd0, 6'd63, 6'd1, 6'd20};
	int                 phase_tx_idle [5] = '{0, 47, 0, 33, 33};
	int                 phase_rx_stall [5] = '{0, 0, 47, 33, 33};

	// small document: empty push and pop, ignored close, skip, both self-close forms
	doc_row_t sample_doc [24] = '{
		'{'{8'h00, 1'b1}, 1'b1, '{ST_OK, 6'd0, EV_NONE}},
		'{'{CH_LT, 1'b0}, 1'b0, '{ST_OK, 6'd0, EV_NONE}},
		'{'{CH_GT, 1'b0}, 1'b1, '{ST_OK, 6'd1, EV_PUSH}},
		'{'{CH_LT, 1'b0}, 1'b0, '{ST_OK, 6'd0, EV_NONE}},
		'{'{CH_SLASH, 1'b0}, 1'b0, '{ST_OK, 6'd0, EV_NONE}},
		'{'{8'h7A, 1'b0}, 1'b0, '{ST_OK, 6'd0, EV_NONE}},
		'{'{CH_SLASH, 1'b0}, 1'b0, '{ST_OK, 6'd0, EV_NONE}},
		'{'{CH_GT, 1'b0}, 1'b1, '{ST_OK, 6'd1, EV_IGNORED}},
		'{'{CH_LT, 1'b0}, 1'b0, '{ST_OK, 6'd0, EV_NONE}},
		'{'{CH_SLASH, 1'b0}, 1'b0, '{ST_OK, 6'd0, EV_NONE}},
		'{'{CH_GT, 1'b0}, 1'b1, '{ST_OK, 6'd0, EV_POP}},
		'{'{CH_LT, 1'b0}, 1'b0, '{ST_OK, 6'd0, EV_NONE}},
		'{'{CH_QUEST, 1'b0}, 1'b0, '{ST_OK, 6'd0, EV_NONE}},
		'{'{8'hFF, 1'b0}, 1'b0, '{ST_OK, 6'd0, EV_NONE}},
		'{'{CH_GT, 1'b0}, 1'b0, '{ST_OK, 6'd0, EV_NONE}},
		'{'{CH_LT, 1'b0}, 1'b0, '{ST_OK, 6'd0, EV_NONE}},
		'{'{8'h80, 1'b0}, 1'b0, '{ST_OK, 6'd0, EV_NONE}},
		'{'{CH_NL, 1'b0}, 1'b0, '{ST_OK, 6'd0, EV_NONE}},
		'{'{CH_SLASH, 1'b0}, 1'b0, '{ST_OK, 6'd0, EV_NONE}},
		'{'{CH_GT, 1'b0}, 1'b1, '{ST_OK, 6'd0, EV_SELF}},
		'{'{CH_LT, 1'b0}, 1'b0, '{ST_OK, 6'd0, EV_NONE}},
		'{'{8'h61, 1'b0}, 1'b0, '{ST_OK, 6'd0, EV_NONE}},
		'{'{CH_SLASH, 1'b0}, 1'b0, '{ST_OK, 6'd0, EV_NONE}},
		'{'{CH_GT, 1'b1}, 1'b1, '{ST_OK, 6'd0, EV_SELF}}
	};

	markup_tag_nesting_checker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_NL;
	endfunction

	// out-of-range limits fold into 1..STACK_DEPTH
	function automatic int cap_of(input logic [LIMIT_W-1:0] v);
		if (v < 1)
			return 1;
		if (v > STACK_DEPTH)
			return STACK_DEPTH;
		return int'(v);
	endfunction

	function automatic void start_tag_name(input bit closing);
		p_closing = closing;
		p_len = 0;
		p_ends_slash = 1'b0;
		p_match = 1'b1;
		p_mode = MODE_NAME;
	endfunction

	// '>' of an opening tag: self-close, push, or overflow
	function automatic void finish_open_tag();
		bit self_close;
		self_close = p_ends_slash || p_saw_slash;
		p_mode = MODE_TEXT;
		if (self_close) begin
			p_event = EV_SELF;
		end else if (p_count >= cap_of(p_limit)) begin
			p_err = ST_STACK_FULL;
		end else begin
			p_lens[p_count] = p_len;
			p_count++;
			p_event = EV_PUSH;
		end
	endfunction

	function automatic void end_of_name(input logic [7:0] c);
		if (p_closing) begin
			// empty stack is caught before the trailing slash test
			if (p_count == 0) begin
				p_err = ST_CLOSE_EMPTY;
				return;
			end
			if (p_ends_slash) begin
				p_event = EV_IGNORED;
			end else if (p_match && p_len == p_lens[p_count-1]) begin
				p_count--;
				p_event = EV_POP;
			end else begin
				p_err = ST_MISMATCH;
				return;
			end
			if (c == CH_GT)
				p_mode = MODE_TEXT;
			else
				p_mode = MODE_CLOSE_REST;
		end else begin
			p_saw_slash = 1'b0;
			if (c == CH_GT)
				finish_open_tag();
			else
				p_mode = MODE_OPEN_REST;
		end
	endfunction

	function automatic void name_char(input logic [7:0] c);
		if (c == CH_GT || is_blank(c)) begin
			end_of_name(c);
			return;
		end
		if (p_len >= NAME_BYTES) begin
			p_err = ST_NAME_LONG;
			return;
		end
		if (p_closing) begin
			if (p_count > 0) begin
				if (p_len >= p_lens[p_count-1] || p_names[p_count-1][p_len] != c)
					p_match = 1'b0;
			end
		end else if (p_count < STACK_DEPTH) begin
			p_names[p_count][p_len] = c;
		end
		p_ends_slash = (c == CH_SLASH);
		p_len++;
	endfunction

	// advance the parser mirror by one byte and return the result it owes
	function automatic result_t parse_byte(input item_t it);
		logic [7:0] c;
		result_t    r;
		c = it.byte_req;
		p_event = EV_NONE;
		if (p_err == ST_OK) begin
			case (p_mode)
				MODE_TEXT: begin
					if (c == CH_LT)
						p_mode = MODE_AFTER_LT;
				end
				MODE_AFTER_LT: begin
					if (c == CH_QUEST || c == CH_BANG) begin
						p_mode = MODE_SKIP;
					end else if (c == CH_SLASH) begin
						start_tag_name(1'b1);
					end else begin
						start_tag_name(1'b0);
						name_char(c);
					end
				end
				MODE_NAME: begin
					name_char(c);
				end
				MODE_OPEN_REST: begin
					if (c == CH_GT)
						finish_open_tag();
					else
						p_saw_slash = (c == CH_SLASH);
				end
				default: begin
					if (c == CH_GT)
						p_mode = MODE_TEXT;
				end
			endcase
			// document ends somewhere other than plain text
			if (p_err == ST_OK && it.last && p_mode != MODE_TEXT)
				p_err = ST_ENDED_IN_TAG;
			if (p_err != ST_OK)
				p_event = EV_NONE;
		end
		r.status = p_err;
		r.depth = DEPTH_W'(p_count);
		r.tag_event = p_event;
		return r;
	endfunction

	// offer one byte, with random idle cycles first; predict once it is taken
	task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
		int      gap;
		result_t want;
		gap = 0;
		while (gap < 24 && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		bytes_sent++;
		want = parse_byte(it);
		if (typed)
			want = typed_res;
		awaited_results.push_back(want);
	endtask

	task automatic emit(input logic [7:0] c, input bit fin = 1'b0);
		item_t it;
		it.byte_req = c;
		it.last = fin;
		send_item(it, 1'b0, '0);
	endtask

	function automatic logic [7:0] pick_byte_except(input logic [7:0] x);
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (c == x);
		return c;
	endfunction

	// name bytes never terminate the name; a first byte must not turn the tag into something else
	function automatic logic [7:0] pick_name_char(input bit first);
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (c == CH_GT || is_blank(c) ||
			(first && (c == CH_QUEST || c == CH_BANG || c == CH_SLASH)));
		return c;
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(2))
			0: return CH_SPACE;
			1: return CH_TAB;
			default: return CH_NL;
		endcase
	endfunction

	task automatic gen_text();
		repeat ($urandom_range(1, 4))
			emit(pick_byte_except(CH_LT), $urandom_range(7) == 0);
	endtask

	// opening tag: pushed, or self-closed by a name ending in '/' or a '/' before '>'
	task automatic gen_open(input bit push);
		int         len;
		int         k;
		bit         slash_name;
		bit         attrs;
		bit         prev_slash;
		logic [7:0] c;
		len = ($urandom_range(15) == 0) ? NAME_BYTES : $urandom_range(6);
		slash_name = !push && $urandom_range(1);
		if (slash_name && len < 2)
			len = 2;
		attrs = (!push && !slash_name) || $urandom_range(1);
		emit(CH_LT);
		for (int i = 0; i < len; i++) begin
			c = pick_name_char(i == 0);
			if (i == len - 1) begin
				if (slash_name)
					c = CH_SLASH;
				else
					while (c == CH_SLASH)
						c = pick_name_char(1'b0);
			end
			if (push)
				gen_names[gen_depth][i] = c;
			emit(c);
		end
		if (push) begin
			gen_lens[gen_depth] = len;
			gen_depth++;
		end
		if (attrs) begin
			emit(pick_blank());
			prev_slash = 1'b0;
			k = $urandom_range(5);
			repeat (k) begin
				c = pick_byte_except(CH_GT);
				prev_slash = (c == CH_SLASH);
				emit(c);
			end
			// a pushed tag must not end in '/', a self-closing one here must
			if (push && prev_slash)
				emit(8'h78);
			if (!push && !slash_name)
				emit(CH_SLASH);
		end
		emit(CH_GT, $urandom_range(7) == 0);
	endtask

	// closing tag: matches the top name, or carries a name ending in '/' and is ignored
	task automatic gen_close(input bit ignored);
		if (ignored) begin
			emit(CH_LT);
			emit(CH_SLASH);
			repeat ($urandom_range(4))
				emit(pick_name_char(1'b0));
			emit(CH_SLASH);
		end else begin
			gen_depth--;
			emit(CH_LT);
			emit(CH_SLASH);
			for (int i = 0; i < gen_lens[gen_depth]; i++)
				emit(gen_names[gen_depth][i]);
		end
		if ($urandom_range(1)) begin
			emit(pick_blank());
			repeat ($urandom_range(4))
				emit(pick_byte_except(CH_GT));
		end
		emit(CH_GT, $urandom_range(7) == 0);
	endtask

	// limit changes only with nothing in flight
	task automatic write_depth_limit(input logic [LIMIT_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		p_limit = v;
		gen_cap = cap_of(v);
	endtask

	// stop offering and wait for every owed result, then settle
	task automatic wait_for_results(input int settle);
		int waited;
		waited = 0;
		item_valid <= 1'b0;
		while (awaited_results.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		if (awaited_results.size() != 0) begin
			fails++;
			$display("%0t: %0d results never arrived", $time, awaited_results.size());
			awaited_results.delete();
		end
		repeat (settle) @(posedge clk);
	endtask

	// result side: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (rx_hold_req > 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				result_ready <= 1'b0;
				hold_left--;
			end else begin
				result_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// compare every result transaction with the oldest owed result
	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			if (awaited_results.size() == 0) begin
				fails++;
				if (fails <= 40)
					$display("%0t: result with none owed: status %0d depth %0d event %0d",
						$time, result.status, result.depth, result.tag_event);
			end else begin
				head = awaited_results.pop_front();
				if (result !== head) begin
					fails++;
					if (fails <= 40) begin
						if (result.status !== head.status)
							$display("%0t: status expected %0d got %0d",
								$time, head.status, result.status);
						if (result.depth !== head.depth)
							$display("%0t: depth expected %0d got %0d",
								$time, head.depth, result.depth);
						if (result.tag_event !== head.tag_event)
							$display("%0t: tag_event expected %0d got %0d",
								$time, head.tag_event, result.tag_event);
					end
				end
			end
		end
	end

	initial begin
		int      start;
		int      r;
		status_t error_goal;
		logic [LIMIT_W-1:0] lim;

		// reset once, released on a clock edge
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed document at the reset limit, no idling
		foreach (sample_doc[i])
			send_item(sample_doc[i].it, sample_doc[i].typed, sample_doc[i].want);

		for (int p = 0; p < 5; p++) begin
			wait_for_results(0);
			tx_idle_pct = phase_tx_idle[p];
			rx_stall_pct = phase_rx_stall[p];
			lim = (p == 4) ? LIMIT_W'($urandom_range(1, 32)) : phase_limit[p];
			write_depth_limit(lim);

			// long result hold-off while bytes keep coming, so the input backs up
			if (p == 0)
				rx_hold_req = 300;

			// nest right up to the limit, then unwind with a few ignored closes mixed in
			while (gen_depth < gen_cap)
				gen_open(1'b1);
			while (gen_depth > 0)
				gen_close($urandom_range(5) == 0);

			// well-formed random markup
			start = bytes_sent;
			while (bytes_sent - start < 80) begin
				r = $urandom_range(99);
				if (r < 25) begin
					gen_text();
				end else if (r < 50) begin
					if (gen_depth < gen_cap)
						gen_open(1'b1);
					else
						gen_close(1'b0);
				end else if (r < 60) begin
					gen_open(1'b0);
				end else if (r < 80) begin
					if (gen_depth > 0)
						gen_close(1'b0);
					else
						gen_open(1'b1);
				end else if (r < 88) begin
					if (gen_depth > 0)
						gen_close(1'b1);
					else
						gen_text();
				end else begin
					// processing instruction or declaration, skipped to '>'
					emit(CH_LT);
					emit($urandom_range(1) ? CH_QUEST : CH_BANG);
					repeat ($urandom_range(6))
						emit(pick_byte_except(CH_GT));
					emit(CH_GT, $urandom_range(7) == 0);
				end
			end
		end

		// errors are sticky until reset, so one broken sequence closes the run
		error_goal = status_t'($urandom_range(1, 5));
		case (error_goal)
			ST_CLOSE_EMPTY: begin
				// close with nothing open, even with a name ending in '/'
				while (gen_depth > 0)
					gen_close(1'b0);
				emit(CH_LT);
				emit(CH_SLASH);
				emit(8'h65);
				if ($urandom_range(1))
					emit(CH_SLASH);
				emit(CH_GT);
			end
			ST_MISMATCH: begin
				// top name with one byte more, or a one-byte name against a full-length top
				if (gen_depth == 0)
					gen_open(1'b1);
				emit(CH_LT);
				emit(CH_SLASH);
				if (gen_lens[gen_depth-1] < NAME_BYTES)
					for (int i = 0; i < gen_lens[gen_depth-1]; i++)
						emit(gen_names[gen_depth-1][i]);
				emit(8'h71);
				emit(CH_GT);
			end
			ST_STACK_FULL: begin
				while (gen_depth < gen_cap)
					gen_open(1'b1);
				emit(CH_LT);
				emit(8'h66);
				emit(CH_GT);
			end
			ST_NAME_LONG: begin
				emit(CH_LT);
				for (int i = 0; i <= NAME_BYTES; i++)
					emit(pick_name_char(i == 0));
				emit(CH_GT);
			end
			default: begin
				// document marked as ending inside a tag name or a skipped section
				emit(CH_LT);
				emit($urandom_range(1) ? 8'h61 : CH_BANG, 1'b1);
			end
		endcase

		// frozen after the error: noise must change nothing
		repeat (12)
			emit(8'($urandom_range(255)), $urandom_range(1));

		wait_for_results(6);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
